// ===== rtl/rmms_pkg.sv =====
// shared constants and control types for the running statistics block
`default_nettype none

package rmms_pkg;

    localparam int SampleWidthDef = 16;
    localparam int CountWidthDef  = 16;
    localparam int SumWidth       = 32;

    // input kind codes
    localparam logic KindSample = 1'b0;
    localparam logic KindClear  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic take;       // input transaction accepted this cycle
        logic div_start;  // start mean division
        logic load_mean;  // capture divider result into mean
        logic load_out;   // copy statistics into output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic cnt_full;   // count is saturated
        logic div_done;   // divider finished this cycle
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/rmms_div.sv =====
// radix-2 restoring divider: signed sum over unsigned nonzero count
`default_nettype none

module rmms_div #(
    parameter int COUNT_WIDTH = rmms_pkg::CountWidthDef
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic signed [rmms_pkg::SumWidth-1:0] i_sum,
    input  wire logic [COUNT_WIDTH-1:0]         i_count,
    output logic                                o_done,
    output logic [rmms_pkg::SumWidth-1:0]       o_quot,
    output logic                                o_neg
);
    import rmms_pkg::*;

    localparam int CntW = $clog2(SumWidth);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CntW-1:0]        r_cnt, n_cnt;
    logic [COUNT_WIDTH-1:0] r_rem, n_rem;
    logic [SumWidth-1:0]    r_quo, n_quo;
    logic [COUNT_WIDTH-1:0] r_den, n_den;
    logic                   r_neg, n_neg;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   fits;
    logic                   last_step;

    always_comb begin
        trial     = {r_rem, r_quo[SumWidth-1]};
        diff      = trial - {1'b0, r_den};
        fits      = trial >= {1'b0, r_den};
        last_step = r_cnt == CntW'(SumWidth - 1);
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_sum[SumWidth-1] ? SumWidth'(-i_sum) : SumWidth'(i_sum);
            n_den  = i_count;
            n_neg  = i_sum[SumWidth-1];
        end else if (r_busy) begin
            n_rem = fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            n_quo = {r_quo[SumWidth-2:0], fits};
            n_cnt = r_cnt + CntW'(1);
            if (last_step) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_neg  = r_neg;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("divider done while still busy");

endmodule

`default_nettype wire

// ===== rtl/rmms_datapath.sv =====
// statistics registers, sum saturation, mean clamp and output register
`default_nettype none

module rmms_datapath #(
    parameter int SAMPLE_WIDTH = rmms_pkg::SampleWidthDef,
    parameter int COUNT_WIDTH  = rmms_pkg::CountWidthDef
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rmms_pkg::t_cmd                    i_cmd,
    input  wire logic                              i_kind,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    output rmms_pkg::t_status                      o_status,
    output logic signed [SAMPLE_WIDTH-1:0]         o_lowest,
    output logic signed [SAMPLE_WIDTH-1:0]         o_highest,
    output logic [COUNT_WIDTH-1:0]                 o_count,
    output logic signed [SAMPLE_WIDTH-1:0]         o_last,
    output logic signed [rmms_pkg::SumWidth-1:0]   o_total,
    output logic signed [SAMPLE_WIDTH-1:0]         o_average,
    output logic                                   o_overflow
);
    import rmms_pkg::*;

    localparam logic [SumWidth:0] PosLim =
        (SumWidth+1)'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
    localparam logic [SumWidth:0] NegLim = PosLim + (SumWidth+1)'(1);
    localparam logic [SAMPLE_WIDTH-1:0] SMax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SMin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] r_min, n_min;
    logic signed [SAMPLE_WIDTH-1:0] r_max, n_max;
    logic signed [SAMPLE_WIDTH-1:0] r_last, n_last;
    logic [COUNT_WIDTH-1:0]         r_count, n_count;
    logic signed [SumWidth-1:0]     r_sum, n_sum;
    logic signed [SAMPLE_WIDTH-1:0] r_mean, n_mean;
    logic                           r_ovf, n_ovf;

    logic signed [SAMPLE_WIDTH-1:0] r_o_low, r_o_high, r_o_last, r_o_avg;
    logic [COUNT_WIDTH-1:0]         r_o_count;
    logic signed [SumWidth-1:0]     r_o_total;
    logic                           r_o_ovf;

    logic                   first;
    logic                   full;
    logic [SumWidth:0]      sum_ext;
    logic [SumWidth-1:0]    sum_sat;
    logic                   div_done;
    logic [SumWidth-1:0]    quot;
    logic                   quot_neg;
    logic [SumWidth:0]      quot_ext;
    logic [SumWidth-1:0]    quot_negated;
    logic [SAMPLE_WIDTH-1:0] mean_clamped;

    rmms_div #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_sum   (r_sum),
        .i_count (r_count),
        .o_done  (div_done),
        .o_quot  (quot),
        .o_neg   (quot_neg)
    );

    always_comb begin
        first    = r_count == '0;
        full     = r_count == '1;
        // sign-extended add, then saturate to the 32-bit range
        sum_ext  = {r_sum[SumWidth-1], r_sum}
                 + {{(SumWidth+1-SAMPLE_WIDTH){i_sample[SAMPLE_WIDTH-1]}}, i_sample};
        if (sum_ext[SumWidth] != sum_ext[SumWidth-1]) begin
            sum_sat = sum_ext[SumWidth] ? {1'b1, {(SumWidth-1){1'b0}}}
                                        : {1'b0, {(SumWidth-1){1'b1}}};
        end else begin
            sum_sat = sum_ext[SumWidth-1:0];
        end

        // mean from quotient magnitude, clamped to the sample range
        quot_ext     = {1'b0, quot};
        quot_negated = -quot;
        if (quot_neg) begin
            mean_clamped = (quot_ext > NegLim) ? SMin : quot_negated[SAMPLE_WIDTH-1:0];
        end else begin
            mean_clamped = (quot_ext > PosLim) ? SMax : quot[SAMPLE_WIDTH-1:0];
        end

        n_min   = r_min;
        n_max   = r_max;
        n_last  = r_last;
        n_count = r_count;
        n_sum   = r_sum;
        n_mean  = r_mean;
        n_ovf   = r_ovf;
        if (i_cmd.take) begin
            if (i_kind == KindClear) begin
                n_min   = '0;
                n_max   = '0;
                n_last  = '0;
                n_count = '0;
                n_sum   = '0;
                n_mean  = '0;
                n_ovf   = 1'b0;
            end else begin
                n_min  = (first || i_sample < r_min) ? i_sample : r_min;
                n_max  = (first || i_sample > r_max) ? i_sample : r_max;
                n_last = i_sample;
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_count = r_count + COUNT_WIDTH'(1);
                    n_sum   = sum_sat;
                end
            end
        end else if (i_cmd.load_mean) begin
            n_mean = mean_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= '0;
            r_max   <= '0;
            r_last  <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_mean  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_min   <= n_min;
            r_max   <= n_max;
            r_last  <= n_last;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_mean  <= n_mean;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_low   <= r_min;
            r_o_high  <= r_max;
            r_o_count <= r_count;
            r_o_last  <= r_last;
            r_o_total <= r_sum;
            r_o_avg   <= r_mean;
            r_o_ovf   <= r_ovf;
        end
    end

    assign o_status.cnt_full = full;
    assign o_status.div_done = div_done;
    assign o_lowest   = r_o_low;
    assign o_highest  = r_o_high;
    assign o_count    = r_o_count;
    assign o_last     = r_o_last;
    assign o_total    = r_o_total;
    assign o_average  = r_o_avg;
    assign o_overflow = r_o_ovf;

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> (r_sum == '0 && r_min == '0 && r_max == '0 && !r_ovf))
        else $error("statistics not zero with empty count");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= r_max)
        else $error("minimum above maximum");

endmodule

`default_nettype wire

// ===== rtl/rmms_ctrl.sv =====
// controller state machine for the running statistics block
`default_nettype none

module rmms_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_kind,
    input  wire logic              i_out_ready,
    input  wire rmms_pkg::t_status i_status,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output rmms_pkg::t_cmd         o_cmd
);
    import rmms_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       take;

    always_comb begin
        o_in_ready       = r_state == S_IDLE;
        take             = i_in_valid && o_in_ready;
        o_cmd.take       = take;
        o_cmd.div_start  = r_state == S_START;
        o_cmd.load_mean  = (r_state == S_WAIT) && i_status.div_done;
        o_cmd.load_out   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_in_kind == KindClear || i_status.cnt_full) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (o_cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_start_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == S_WAIT)
        else $error("division start not followed by wait");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done state");

endmodule

`default_nettype wire

// ===== rtl/running_min_max_sum_mean.sv =====
// running min, max, count, sum and mean over a stream of fixed-point samples
// a sample's result waits for the mean, which is formed by the
//   32-step radix-2 divider, one quotient bit per cycle
// a clear, or a sample arriving with the count saturated, skips the divider and goes straight to the output register
// no new input is taken until the last result is loaded for output, which waits while m_tready is low
// reset: synchronous active-low i_rst_n zeroes all statistics and drops valid
`default_nettype none

module running_min_max_sum_mean #(
    parameter int SAMPLE_WIDTH = rmms_pkg::SampleWidthDef,
    parameter int COUNT_WIDTH  = rmms_pkg::CountWidthDef
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,

    // input stream
    input  wire logic  s_tvalid,
    output logic       s_tready,
    // sample_value
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // kind
    input  wire logic [0:0] s_tuser,

    // result stream
    output logic       m_tvalid,
    input  wire logic  m_tready,
    // lowest, highest, sample_count, last_value, total, average
    output logic [((4*SAMPLE_WIDTH+COUNT_WIDTH+rmms_pkg::SumWidth+7)/8)*8-1:0] m_tdata,
    // overflow
    output logic [0:0] m_tuser
);
    import rmms_pkg::*;

    localparam int FieldW = 4*SAMPLE_WIDTH + COUNT_WIDTH + SumWidth;
    localparam int TdataW = ((FieldW + 7) / 8) * 8;

    t_cmd    cmd;
    t_status status;

    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic signed [SAMPLE_WIDTH-1:0] lowest, highest, last_value, average;
    logic [COUNT_WIDTH-1:0]         sample_count;
    logic signed [SumWidth-1:0]     total;
    logic                           overflow;

    // sample sits in the low bits of tdata
    assign sample = s_tdata[SAMPLE_WIDTH-1:0];

    // controller: sequences accept, division and result hand-off
    rmms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .i_in_kind   (s_tuser[0]),
        .i_out_ready (m_tready),
        .i_status    (status),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .o_cmd       (cmd)
    );

    // datapath: statistics, divider and output register
    rmms_datapath #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_kind     (s_tuser[0]),
        .i_sample   (sample),
        .o_status   (status),
        .o_lowest   (lowest),
        .o_highest  (highest),
        .o_count    (sample_count),
        .o_last     (last_value),
        .o_total    (total),
        .o_average  (average),
        .o_overflow (overflow)
    );

    // pack result fields from the lowest bit up, zero filled to whole bytes
    assign m_tdata = TdataW'({average, total, last_value, sample_count, highest, lowest});
    assign m_tuser = overflow;

endmodule

`default_nettype wire
